@@ hw/rtl/seven_segment_link_master_top_macros.svh @@
// assertion helpers for the rtl files; only ssl_fifo includes them
`ifndef SEVEN_SEGMENT_LINK_MASTER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_LINK_MASTER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssl check failed");

// next-cycle implication, checked outside reset
`define SSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssl check failed");

`endif

@@ hw/rtl/ssl_pkg.sv @@
package ssl_pkg;

    // default number of display positions
    localparam int POSITIONS_DEF = 4;
    // positions that have an input field
    localparam int IN_POSITIONS = 4;
    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // request opcodes
    localparam logic [1:0] OP_DIGITS = 2'd0;
    localparam logic [1:0] OP_RAW    = 2'd1;
    localparam logic [1:0] OP_OFF    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_HALF_BIT_TICKS = 3'd0;
    localparam logic [2:0] REG_DATA_CMD       = 3'd1;
    localparam logic [2:0] REG_ADDR_CMD       = 3'd2;
    localparam logic [2:0] REG_ON_BASE        = 3'd3;
    localparam logic [2:0] REG_OFF_CMD        = 3'd4;
    localparam logic [2:0] REG_BLANK          = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_HALF_BIT_TICKS = 16'd2000;
    localparam logic [7:0]  RST_DATA_CMD       = 8'h40;
    localparam logic [7:0]  RST_ADDR_CMD       = 8'hc0;
    localparam logic [7:0]  RST_ON_BASE        = 8'h88;
    localparam logic [7:0]  RST_OFF_CMD        = 8'h80;
    localparam logic [7:0]  RST_BLANK          = 8'h00;

    localparam logic [7:0] DOT_BIT        = 8'b1000_0000;
    localparam logic [7:0] MAX_LEVEL      = 8'h07;
    localparam logic [7:0] SEG_MAP [10]   = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                              8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [7:0]  data_command;
        logic [7:0]  address_command;
        logic [7:0]  display_on_base;
        logic [7:0]  display_off_command;
        logic [7:0]  blank_pattern;
    } t_cfg;

    // one byte or empty frame for the wire
    typedef struct packed {
        logic [7:0] wire_byte;
        logic       frame_first;
        logic       frame_final;
        logic       empty_frame;
        logic       run_last;
    } t_item;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] position_0;
        logic [7:0] position_1;
        logic [7:0] position_2;
        logic [7:0] position_3;
        logic [7:0] shown_count;
        logic [7:0] level;
        logic [7:0] dot_position;
    } t_req;

    typedef enum logic {
        F_IDLE,
        F_EMIT
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_WIRE,
        B_HOLD
    } t_bstate;

    // segment pattern of a value taken modulo ten
    function automatic logic [7:0] seg_of(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  quot;
        logic [7:0]  rem;
        prod = 16'(v) * 16'd205;
        quot = prod[15:11];
        rem  = v - 8'(quot) * 8'd10;
        seg_of = SEG_MAP[rem[3:0]];
    endfunction

endpackage

@@ hw/rtl/ssl_ifs.sv @@
// request channel
interface ssl_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] position_0;
    logic [7:0] position_1;
    logic [7:0] position_2;
    logic [7:0] position_3;
    logic [7:0] shown_count;
    logic [7:0] level;
    logic [7:0] dot_position;

    modport source (output valid, output opcode, output position_0, output position_1,
                    output position_2, output position_3, output shown_count,
                    output level, output dot_position, input ready);
    modport sink   (input valid, input opcode, input position_0, input position_1,
                    input position_2, input position_3, input shown_count,
                    input level, input dot_position, output ready);
endinterface

// result channel
interface ssl_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       frame_first;
    logic       frame_final;
    logic       empty_frame;
    logic       run_last;

    modport source (output valid, output wire_byte, output frame_first, output frame_final,
                    output empty_frame, output run_last, input ready);
    modport sink   (input valid, input wire_byte, input frame_first, input frame_final,
                    input empty_frame, input run_last, output ready);
endinterface

// configuration write channel
interface ssl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/seven_segment_link_master_top.sv @@
// Two-wire seven-segment display link master. Each request on i_req turns into three
// wire frames, and every byte (or empty middle frame) comes back on o_res as one transfer
// with its frame flags; run_last marks the final transfer of a request, and opcode three
// yields nothing. A byte costs 18 wire half periods plus 2 for a leading start and 2 for a
// trailing stop, an empty frame costs 4, and the length of a half period is set by
// half_bit_ticks. With four positions a digits request is 138 half periods, raw 156 and
// off 48. The back end's half-period timer sets the pace; the front end builds one
// transfer per cycle into a four-entry queue while it is not full and takes a new request
// once the previous one is fully queued. Configuration writes are always accepted.
module seven_segment_link_master_top import ssl_pkg::*; #(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssl_req_if.sink    i_req,
    ssl_res_if.source  o_res,
    ssl_cfg_if.sink    i_cfg
);

    t_cfg   r_cfg, n_cfg;
    logic   q_push, q_full, q_pop, q_empty;
    t_item  q_in, q_out;

    assign i_cfg.ready = 1'b1;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HALF_BIT_TICKS: n_cfg.half_bit_ticks      = i_cfg.data;
                REG_DATA_CMD:       n_cfg.data_command        = i_cfg.data[7:0];
                REG_ADDR_CMD:       n_cfg.address_command     = i_cfg.data[7:0];
                REG_ON_BASE:        n_cfg.display_on_base     = i_cfg.data[7:0];
                REG_OFF_CMD:        n_cfg.display_off_command = i_cfg.data[7:0];
                REG_BLANK:          n_cfg.blank_pattern       = i_cfg.data[7:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{half_bit_ticks: RST_HALF_BIT_TICKS, data_command: RST_DATA_CMD,
                       address_command: RST_ADDR_CMD, display_on_base: RST_ON_BASE,
                       display_off_command: RST_OFF_CMD, blank_pattern: RST_BLANK};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // request classification and byte building
    ssl_front #(
        .POSITIONS (POSITIONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_push  (q_push),
        .o_item  (q_in),
        .i_full  (q_full)
    );

    // decoupling queue
    ssl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    // wire pacing and result output
    ssl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_half_bit_ticks (r_cfg.half_bit_ticks),
        .i_empty          (q_empty),
        .o_pop            (q_pop),
        .i_item           (q_out),
        .o_res            (o_res)
    );

endmodule

@@ hw/rtl/ssl_front.sv @@
module ssl_front import ssl_pkg::*; #(
    parameter int POSITIONS = POSITIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    ssl_req_if.sink   i_req,
    output logic      o_push,
    output t_item     o_item,
    input  logic      i_full
);

    localparam int STEPS = POSITIONS + 4;
    localparam int SW    = $clog2(STEPS);

    t_fstate         r_state, n_state;
    logic [SW-1:0]   r_step, n_step;
    t_req            r_req;

    logic [SW-1:0]   seg_idx;
    logic [SW-1:0]   last_step;
    logic [7:0]      pos_sel;
    logic [7:0]      digit_seg;
    logic [7:0]      count_sat;
    logic [7:0]      bright;
    logic [7:0]      pos_arr [IN_POSITIONS];

    // state and step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= '{opcode: i_req.opcode, position_0: i_req.position_0,
                       position_1: i_req.position_1, position_2: i_req.position_2,
                       position_3: i_req.position_3, shown_count: i_req.shown_count,
                       level: i_req.level, dot_position: i_req.dot_position};
        end
    end

    // segment byte of the current position
    always_comb begin
        pos_arr[0] = r_req.position_0;
        pos_arr[1] = r_req.position_1;
        pos_arr[2] = r_req.position_2;
        pos_arr[3] = r_req.position_3;
        seg_idx    = r_step - SW'(2);
        pos_sel    = 8'h00;
        for (int j = 0; j < POSITIONS; j++) begin
            if (j < IN_POSITIONS && seg_idx == SW'(j)) begin
                pos_sel = pos_arr[j[1:0]];
            end
        end
        count_sat = (r_req.shown_count > 8'(POSITIONS)) ? 8'(POSITIONS) : r_req.shown_count;
        digit_seg = seg_of(pos_sel);
        if (8'(seg_idx) == r_req.dot_position) begin
            digit_seg = digit_seg | DOT_BIT;
        end
        if (8'(seg_idx) >= count_sat) begin
            digit_seg = 8'h00;
        end
        bright = (r_req.level > MAX_LEVEL) ? MAX_LEVEL : r_req.level;
    end

    // item at the current step
    always_comb begin
        case (r_req.opcode)
            OP_OFF:  last_step = SW'(2);
            OP_RAW:  last_step = SW'(POSITIONS + 3);
            default: last_step = SW'(POSITIONS + 2);
        endcase
        o_item = '{wire_byte: i_cfg.display_on_base | bright, frame_first: 1'b1,
                   frame_final: 1'b1, empty_frame: 1'b0, run_last: 1'b0};
        if (r_step == '0) begin
            o_item.wire_byte = i_cfg.data_command;
        end else if (r_req.opcode == OP_OFF) begin
            if (r_step == SW'(1)) begin
                o_item.wire_byte   = 8'h00;
                o_item.empty_frame = 1'b1;
            end else begin
                o_item.wire_byte = i_cfg.display_off_command;
            end
        end else if (r_step == SW'(1)) begin
            o_item.wire_byte   = i_cfg.address_command;
            o_item.frame_final = 1'b0;
        end else if (r_step <= SW'(POSITIONS + 1)) begin
            o_item.frame_first = 1'b0;
            if (r_req.opcode == OP_DIGITS) begin
                o_item.wire_byte   = digit_seg;
                o_item.frame_final = (seg_idx == SW'(POSITIONS - 1));
            end else begin
                o_item.wire_byte   = pos_sel;
                o_item.frame_final = 1'b0;
            end
        end else if (r_req.opcode == OP_RAW && r_step == SW'(POSITIONS + 2)) begin
            o_item.wire_byte   = i_cfg.blank_pattern;
            o_item.frame_first = 1'b0;
        end
        o_item.run_last = (r_step == last_step);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_push      = 1'b0;
        i_req.ready = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_step = '0;
                    if (i_req.opcode != OP_NONE) begin
                        n_state = F_EMIT;
                    end
                end
            end
            F_EMIT: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    if (o_item.run_last) begin
                        n_state = F_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/ssl_fifo.sv @@
`include "seven_segment_link_master_top_macros.svh"

module ssl_fifo import ssl_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push && !o_full) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push && !o_full, i_pop && !o_empty})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue bookkeeping checks
    `SSL_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `SSL_ASSERT_NOW(a_no_pop_empty, r_count == '0, !i_pop)
    `SSL_ASSERT_NOW(a_no_push_full, r_count == CW'(DEPTH), !i_push)

endmodule

@@ hw/rtl/ssl_back.sv @@
module ssl_back import ssl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_half_bit_ticks,
    input  logic        i_empty,
    output logic        o_pop,
    input  t_item       i_item,
    ssl_res_if.source   o_res
);

    localparam logic [4:0] HALVES_BYTE  = 5'd18;
    localparam logic [4:0] HALVES_EDGE  = 5'd2;
    localparam logic [4:0] HALVES_EMPTY = 5'd4;

    t_bstate      r_state, n_state;
    t_item        r_cur, n_cur;
    t_item        r_out, n_out;
    logic         r_out_valid, n_out_valid;
    logic [15:0]  r_ticks, n_ticks;
    logic [4:0]   r_halves, n_halves;
    logic [4:0]   item_halves;

    assign o_res.valid       = r_out_valid;
    assign o_res.wire_byte   = r_out.wire_byte;
    assign o_res.frame_first = r_out.frame_first;
    assign o_res.frame_final = r_out.frame_final;
    assign o_res.empty_frame = r_out.empty_frame;
    assign o_res.run_last    = r_out.run_last;

    // wire half periods for one item: a byte plus start and stop edges, or an empty frame
    always_comb begin
        if (i_item.empty_frame) begin
            item_halves = HALVES_EMPTY;
        end else begin
            item_halves = HALVES_BYTE
                        + (i_item.frame_first ? HALVES_EDGE : 5'd0)
                        + (i_item.frame_final ? HALVES_EDGE : 5'd0);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // timing and payload registers
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_out    <= n_out;
        r_ticks  <= n_ticks;
        r_halves <= n_halves;
    end

    // wire pacing and result handoff
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_ticks     = r_ticks;
        n_halves    = r_halves;
        o_pop       = 1'b0;
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    n_cur    = i_item;
                    n_ticks  = i_half_bit_ticks - 16'd1;
                    n_halves = item_halves;
                    n_state  = B_WIRE;
                end
            end
            B_WIRE: begin
                if (r_ticks == '0) begin
                    if (r_halves == 5'd1) begin
                        n_state = B_HOLD;
                    end else begin
                        n_halves = r_halves - 5'd1;
                        n_ticks  = i_half_bit_ticks - 16'd1;
                    end
                end else begin
                    n_ticks = r_ticks - 16'd1;
                end
            end
            B_HOLD: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_cur;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

endmodule
